@@ src/keypad_time_date_entry_top_macros.svh @@
// Assertion macros for the keypad entry top level.
`ifndef KEYPAD_TIME_DATE_ENTRY_TOP_MACROS_SVH
`define KEYPAD_TIME_DATE_ENTRY_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define KTE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kte assertion failed");

// Next-cycle implication, checked out of reset.
`define KTE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kte assertion failed");

`endif

@@ src/kte_pkg.sv @@
// Shared types and constants for the keypad time and date entry block.
package kte_pkg;

    localparam int VALUE_W = 25;
    localparam int CNT_W   = 3;
    localparam int TICK_W  = 16;
    localparam int KEY_W   = 8;
    localparam int DIGIT_W = 4;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic [KEY_W-1:0] KEY_DIGIT_LO = 8'd48;
    localparam logic [KEY_W-1:0] KEY_DIGIT_HI = 8'd57;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_TWELVE_HOUR   = 3'd0;
    localparam logic [2:0] REG_RESET_KEY     = 3'd1;
    localparam logic [2:0] REG_SET_TIME_KEY  = 3'd2;
    localparam logic [2:0] REG_SET_DATE_KEY  = 3'd3;
    localparam logic [2:0] REG_TIMEOUT_TICKS = 3'd4;

    typedef enum logic [1:0] {
        PH_STANDBY = 2'd0,
        PH_TIME    = 2'd1,
        PH_DATE    = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_RESET       = 3'd1,
        EV_COMMIT_TIME = 3'd2,
        EV_COMMIT_DATE = 3'd3,
        EV_CANCEL      = 3'd4,
        EV_START_TIME  = 3'd5,
        EV_START_DATE  = 3'd6
    } event_t;

    typedef struct packed {
        logic              twelve_hour;
        logic [KEY_W-1:0]  reset_key;
        logic [KEY_W-1:0]  set_time_key;
        logic [KEY_W-1:0]  set_date_key;
        logic [TICK_W-1:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        phase_t             phase;
        logic [VALUE_W-1:0] value;
        logic [CNT_W-1:0]   count;
        logic [DIGIT_W-1:0] last_digit;
        logic [TICK_W-1:0]  time_left;
    } entry_t;

    typedef struct packed {
        event_t             event_res;
        logic [VALUE_W-1:0] value;
        phase_t             phase;
    } result_t;

    function automatic logic [DIGIT_W-1:0] dmin(input logic [DIGIT_W-1:0] a,
                                                 input logic [DIGIT_W-1:0] b);
        dmin = (a < b) ? a : b;
    endfunction

    function automatic logic [DIGIT_W-1:0] dmax(input logic [DIGIT_W-1:0] a,
                                                 input logic [DIGIT_W-1:0] b);
        dmax = (a > b) ? a : b;
    endfunction

endpackage

@@ src/kte_regs.sv @@
// APB configuration registers for the keypad entry block.
module kte_regs
    import kte_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_TWELVE_HOUR:   cfg_next.twelve_hour   = pwdata[0];
                REG_RESET_KEY:     cfg_next.reset_key     = pwdata[KEY_W-1:0];
                REG_SET_TIME_KEY:  cfg_next.set_time_key  = pwdata[KEY_W-1:0];
                REG_SET_DATE_KEY:  cfg_next.set_date_key  = pwdata[KEY_W-1:0];
                REG_TIMEOUT_TICKS: cfg_next.timeout_ticks = pwdata[TICK_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_TWELVE_HOUR:   prdata = {{(DATA_W-1){1'b0}}, cfg_reg.twelve_hour};
            REG_RESET_KEY:     prdata = {{(DATA_W-KEY_W){1'b0}}, cfg_reg.reset_key};
            REG_SET_TIME_KEY:  prdata = {{(DATA_W-KEY_W){1'b0}}, cfg_reg.set_time_key};
            REG_SET_DATE_KEY:  prdata = {{(DATA_W-KEY_W){1'b0}}, cfg_reg.set_date_key};
            REG_TIMEOUT_TICKS: prdata = {{(DATA_W-TICK_W){1'b0}}, cfg_reg.timeout_ticks};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.twelve_hour   <= 1'b0;
            cfg_reg.reset_key     <= 8'd70;
            cfg_reg.set_time_key  <= 8'd69;
            cfg_reg.set_date_key  <= 8'd67;
            cfg_reg.timeout_ticks <= 16'd10000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ src/kte_step.sv @@
// Next-state and result logic for one key press or tick.
module kte_step
    import kte_pkg::*;
(
    input  cfg_t             cfg,
    input  entry_t           cur,
    input  logic             mode,
    input  logic [KEY_W-1:0] key_code,
    output entry_t           nxt,
    output result_t          res
);

    logic [DIGIT_W-1:0] digit;
    logic [DIGIT_W-1:0] dc;
    logic               is_digit;
    logic               commit;
    logic [VALUE_W-1:0] appended;
    logic [VALUE_W-1:0] commit_val;
    entry_t             standby_st;
    entry_t             start_st;
    event_t             ev;

    assign is_digit = (key_code >= KEY_DIGIT_LO) && (key_code <= KEY_DIGIT_HI);
    assign digit    = DIGIT_W'(key_code - KEY_DIGIT_LO);

    // Position-dependent clamp; commit once the last position is reached
    always_comb
    begin
        dc     = digit;
        commit = 1'b0;
        if (cur.phase == PH_TIME)
        begin
            case (cur.count)
                3'd0: dc = dmin(digit, cfg.twelve_hour ? 4'd1 : 4'd2);
                3'd1:
                begin
                    if (cfg.twelve_hour)
                        dc = (cur.value == '0) ? dmax(4'd1, digit) : dmin(4'd2, digit);
                    else if (cur.value == VALUE_W'(2))
                        dc = dmin(4'd3, digit);
                end
                3'd2:    dc = dmin(4'd5, digit);
                default: commit = 1'b1;
            endcase
        end
        else
        begin
            case (cur.count)
                3'd0: dc = dmin(4'd3, digit);
                3'd1:
                begin
                    if (cur.value == VALUE_W'(3))
                        dc = dmin(4'd1, digit);
                end
                3'd2: dc = dmin(4'd1, digit);
                3'd3:
                begin
                    if (cur.last_digit == 4'd1)
                        dc = dmin(4'd2, digit);
                end
                3'd4, 3'd5, 3'd6: dc = digit;
                default: commit = 1'b1;
            endcase
        end
    end

    // v*10 + d, wrapping at the value width
    assign appended = (cur.value << 3) + (cur.value << 1) + VALUE_W'(dc);

    always_comb
    begin
        standby_st = '{phase: PH_STANDBY, value: '0, count: '0, last_digit: '0,
                       time_left: '0};
        start_st   = '{phase: PH_STANDBY, value: '0, count: '0, last_digit: '0,
                       time_left: cfg.timeout_ticks};
        nxt        = cur;
        ev         = EV_NONE;
        commit_val = '0;

        if (mode)
        begin
            if (cur.phase != PH_STANDBY)
            begin
                if (cur.time_left <= TICK_W'(1))
                begin
                    nxt = standby_st;
                    ev  = EV_CANCEL;
                end
                else
                begin
                    nxt.time_left = cur.time_left - TICK_W'(1);
                end
            end
        end
        else if (key_code == cfg.reset_key)
        begin
            nxt = standby_st;
            ev  = EV_RESET;
        end
        else if (key_code == cfg.set_time_key)
        begin
            if (cur.phase == PH_STANDBY)
            begin
                nxt       = start_st;
                nxt.phase = PH_TIME;
                ev        = EV_START_TIME;
            end
            else if (cur.phase == PH_TIME)
            begin
                nxt = standby_st;
                ev  = EV_CANCEL;
            end
        end
        else if (key_code == cfg.set_date_key)
        begin
            if (cur.phase == PH_STANDBY)
            begin
                nxt       = start_st;
                nxt.phase = PH_DATE;
                ev        = EV_START_DATE;
            end
            else if (cur.phase == PH_DATE)
            begin
                nxt = standby_st;
                ev  = EV_CANCEL;
            end
        end
        else if (is_digit && cur.phase != PH_STANDBY)
        begin
            if (commit)
            begin
                nxt        = standby_st;
                commit_val = appended;
                ev         = (cur.phase == PH_TIME) ? EV_COMMIT_TIME : EV_COMMIT_DATE;
            end
            else
            begin
                nxt.value      = appended;
                nxt.count      = cur.count + CNT_W'(1);
                nxt.last_digit = dc;
            end
        end

        res.event_res = ev;
        res.value     = (ev == EV_COMMIT_TIME || ev == EV_COMMIT_DATE) ? commit_val
                                                                       : nxt.value;
        res.phase     = nxt.phase;
    end

endmodule

@@ src/keypad_time_date_entry_top.sv @@
// Keypad time and date entry: top level with input and result registers.
//
//  channel  direction  handshake          payload
//  s_       in         s_tvalid/s_tready  tdata = key_code, tuser = mode
//  m_       out        m_tvalid/m_tready  tdata = event_res, value, phase
//  apb      in         psel/penable       five config registers at 4*i
//
// One request per cycle sustained while the result is not stalled; each request passes
// through the input register and then the result register.
// The entry state updates as the request moves from input to result register.
// A stalled result holds the input register; s_tready then follows m_tready.
// rst_n clears entry state to standby and the registers to their defaults.
`include "keypad_time_date_entry_top_macros.svh"

module keypad_time_date_entry_top
    import kte_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] key_code
    input  logic              s_tuser,   // [0] mode
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // [2:0] event_res, [27:3] value, [29:28] phase
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t             cfg;
    entry_t           st_reg;
    entry_t           st_next;
    entry_t           st_calc;
    result_t          res_calc;
    result_t          res_reg;
    result_t          res_next;
    logic             in_valid_reg;
    logic             in_valid_next;
    logic             in_mode_reg;
    logic             in_mode_next;
    logic [KEY_W-1:0] in_key_reg;
    logic [KEY_W-1:0] in_key_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             advance;
    logic             take_in;

    kte_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kte_step u_step (
        .cfg      (cfg),
        .cur      (st_reg),
        .mode     (in_mode_reg),
        .key_code (in_key_reg),
        .nxt      (st_calc),
        .res      (res_calc)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign take_in  = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, res_reg.phase, res_reg.value, res_reg.event_res};

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_mode_next   = in_mode_reg;
        in_key_next    = in_key_reg;
        st_next        = st_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;

        if (take_in)
        begin
            in_valid_next = 1'b1;
            in_mode_next  = s_tuser;
            in_key_next   = s_tdata;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        if (advance)
        begin
            st_next        = st_calc;
            res_next       = res_calc;
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '{phase: PH_STANDBY, value: '0, count: '0,
                               last_digit: '0, time_left: '0};
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            st_reg        <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_mode_reg <= in_mode_next;
        in_key_reg  <= in_key_next;
        res_reg     <= res_next;
    end

    `KTE_ASSERT_NOW(a_standby_clear, st_reg.phase == PH_STANDBY,
        st_reg.value == '0 && st_reg.count == '0)
    `KTE_ASSERT_NOW(a_time_count, st_reg.phase == PH_TIME, st_reg.count <= CNT_W'(3))
    `KTE_ASSERT_NOW(a_commit_standby,
        m_tvalid && (res_reg.event_res == EV_COMMIT_TIME ||
                     res_reg.event_res == EV_COMMIT_DATE),
        res_reg.phase == PH_STANDBY)
    `KTE_ASSERT_NEXT(a_held_request, in_valid_reg && !advance, in_valid_reg)

endmodule
